FILE: rtl/iirl_pkg.sv
// Package for the indexed insert/remove list.
// Holds operation and status codes, cell control type and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iirl_pkg;

  localparam int unsigned CAPACITY_DEF   = 32;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_INS  = 2'd1,
    SH_REM  = 2'd2,
    SH_SET  = 2'd3
  } shift_e;

  typedef struct packed {
    shift_e           mode;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/iirl_cell.sv
// One storage cell of the list: holds an entry and takes from its neighbors or from the request word.
// Depends on iirl_pkg for the cell control type.
`timescale 1ns / 1ps
`default_nettype none

module iirl_cell
  import iirl_pkg::*;
#(
  parameter int unsigned IDX        = 0,
  parameter int unsigned IDX_W      = 7,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [DATA_WIDTH-1:0] word_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  output logic      [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [IDX_W-1:0]      pos_w;
  logic                  at_pos, above_pos;

  assign pos_w     = IDX_W'(ctrl_i.pos);
  assign at_pos    = (pos_w == IDX_W'(IDX));
  assign above_pos = (IDX_W'(IDX) > pos_w);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.mode)
      SH_INS: begin
        if (above_pos) begin
          data_d = left_i;
        end else if (at_pos) begin
          data_d = word_i;
        end
      end
      SH_REM: begin
        if (above_pos || at_pos) begin
          data_d = right_i;
        end
      end
      SH_SET: begin
        if (at_pos) begin
          data_d = word_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: rtl/indexed_insert_remove_list.sv
// Top level of the indexed insert/remove list: decode, length counter,
// read select and result register around a row of iirl_cell.
// Depends on iirl_pkg and iirl_cell.
//
//   channel   ports                                 direction
//   request   start, busy, func_i, position_i,      in, busy out
//             value_i
//   result    done_o, read_value_o, length_now_o,   out
//             status_o
//
// One request per cycle; its result strobes on done_o in the cycle after
// acceptance. All cells shift in the same edge, and busy stays low. Reset
// clears the length counter and the result strobe; entry contents are
// undefined until written. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module indexed_insert_remove_list
  import iirl_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [POS_W-1:0]    position_i,
  input  wire logic [VALUE_W-1:0]  value_i,
  output logic                     done_o,
  output logic [VALUE_W-1:0]       read_value_o,
  output logic [LEN_W-1:0]         length_now_o,
  output logic [STATUS_W-1:0]      status_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  done_q;
  logic [VALUE_W-1:0]    rd_q;
  logic [LEN_W-1:0]      len_q;
  status_e               status_q, status_d;

  logic                  accept;
  op_e                   op;
  logic [CMP_W-1:0]      pos_c, cnt_c, cap_c;
  logic [63:0]           value_ext, rd_ext;
  logic [DATA_WIDTH-1:0] word, rd_word, rd_sel;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign op        = op_e'(func_i);
  assign pos_c     = CMP_W'(position_i);
  assign cnt_c     = CMP_W'(count_q);
  assign cap_c     = CMP_W'(CAPACITY);
  assign value_ext = 64'(value_i);
  assign word      = value_ext[DATA_WIDTH-1:0];

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos_c == CMP_W'(i)) begin
        rd_sel = rd_sel | cell_q[i];
      end
    end
  end

  always_comb begin
    count_d   = count_q;
    status_d  = ST_OK;
    rd_word   = '0;
    ctrl.mode = SH_HOLD;
    ctrl.pos  = position_i;
    if (accept) begin
      if (op == OP_INSERT) begin
        if (pos_c > cnt_c) begin
          status_d = ST_RANGE;
        end else if (cnt_c >= cap_c) begin
          status_d = ST_FULL;
        end else begin
          ctrl.mode = SH_INS;
          count_d   = count_q + CNT_W'(1);
        end
      end else if (pos_c >= cnt_c) begin
        status_d = ST_RANGE;
      end else begin
        case (op)
          OP_REMOVE: begin
            ctrl.mode = SH_REM;
            count_d   = count_q - CNT_W'(1);
          end
          OP_GET:  rd_word = rd_sel;
          OP_SET:  ctrl.mode = SH_SET;
          default: ctrl.mode = SH_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = word;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_q[g];
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end
    iirl_cell #(
      .IDX        (g),
      .IDX_W      (CMP_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .word_i  (word),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_q[g])
    );
  end

  assign rd_ext = 64'(rd_word);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q     <= rd_ext[VALUE_W-1:0];
      len_q    <= LEN_W'(count_d);
      status_q <= status_d;
    end
  end

  assign done_o       = done_q;
  assign read_value_o = rd_q;
  assign length_now_o = len_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire
